// ===== rtl/core/vaa_pkg.sv =====
// ============================================================================
// vaa_pkg: shared types, codes and helpers of the vector angle unit
// Request codes, per-stage side information and the byte arithmetic used
// by the normalizer, the divider and the angle unfold.
// ============================================================================
package vaa_pkg;

    // Request kinds carried on req_type
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // Angle constants, 256 steps per turn
    localparam logic [7:0] ANGLE_QUARTER = 8'h40;
    localparam logic [7:0] ANGLE_HALF    = 8'h80;

    // Quotient width and normalizer thresholds
    localparam int unsigned QUOT_W       = 5;
    localparam logic [2:0]  POS_RIGHT_LIM = 3'd4;
    localparam logic [2:0]  POS_TOP       = 3'd7;

    // Request info that rides along stages 1 to 4
    typedef struct packed {
        logic       is_load;
        logic [4:0] idx;
        logic [7:0] val;
    } req_t;

    // Octant fold decisions, undone after the table read
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } fold_t;

    // One restoring divide step
    typedef struct packed {
        logic       q_bit;
        logic [7:0] rem;
    } div_step_t;

    // 8-bit two's-complement negate; 0x80 maps to itself
    function automatic logic [7:0] neg8(input logic [7:0] v);
        return (~v) + 8'd1;
    endfunction

    // Compare, conditionally subtract, then shift the remainder within 8 bits
    function automatic div_step_t div_step(input logic [7:0] rem, input logic [7:0] den);
        div_step_t res;
        logic [7:0] diff;
        res.q_bit = (rem >= den);
        diff      = res.q_bit ? (rem - den) : rem;
        res.rem   = {diff[6:0], 1'b0};
        return res;
    endfunction

endpackage

// ===== rtl/core/vector_angle_atan2_unit.sv =====
// ============================================================================
// vector_angle_atan2_unit: pipelined 8-bit atan2 with octant folding
// The angle strobe rises once a compute beat has passed the stage 1 to 5 registers and done_reg.
// Throughput: one beat per cycle; busy is always low, nothing ever stalls.
// Load beats write the angle table in pipeline order and give no result.
// Reset clears the stage valid bits; the angle table is undefined until written.
// ============================================================================
module vector_angle_atan2_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [4:0]         table_index,
    input  logic [7:0]         table_value,
    input  logic signed [15:0] delta_x,
    input  logic signed [15:0] delta_y,
    output logic               done,
    output logic [7:0]         angle
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic                         s1_valid_reg, s1_valid_next;
    vaa_pkg::req_t                s1_req_reg, s1_req_next;
    logic [7:0]                   s1_x_reg, s1_x_next;
    logic [7:0]                   s1_y_reg, s1_y_next;

    logic                         s2_valid_reg;
    vaa_pkg::req_t                s2_req_reg;
    vaa_pkg::fold_t               s2_fold_reg, s2_fold_next;
    logic [7:0]                   s2_num_reg, s2_num_next;
    logic [7:0]                   s2_den_reg, s2_den_next;

    logic                         s3_valid_reg;
    vaa_pkg::req_t                s3_req_reg;
    vaa_pkg::fold_t               s3_fold_reg;
    logic [7:0]                   s3_rem_reg, s3_rem_next;
    logic [7:0]                   s3_den_reg;
    logic [2:0]                   s3_q_reg, s3_q_next;

    logic                         s4_valid_reg;
    vaa_pkg::req_t                s4_req_reg;
    vaa_pkg::fold_t               s4_fold_reg;
    logic [vaa_pkg::QUOT_W-1:0]   s4_q_reg, s4_q_next;

    logic                         s5_valid_reg;
    vaa_pkg::fold_t               s5_fold_reg;
    logic [7:0]                   s5_data_reg;

    logic                         done_reg;
    logic [7:0]                   angle_reg, angle_next;

    logic [7:0]                   angle_mem [TABLE_DEPTH];

    // The pipeline takes a beat every cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: merge magnitudes, find top bit, scale both values to a byte
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [7:0]  hx;
        logic [7:0]  hy;
        logic [7:0]  merged;
        logic [2:0]  pos;
        logic [2:0]  shift_amt;

        ux = delta_x;
        uy = delta_y;
        hx = ux[15] ? vaa_pkg::neg8(ux[15:8]) : ux[15:8];
        hy = uy[15] ? vaa_pkg::neg8(uy[15:8]) : uy[15:8];
        merged = hx | hy;

        // position is one above the top set bit among bits 6..0, else zero
        pos = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (merged[i])
            begin
                pos = 3'(i + 1);
            end
        end

        if (pos < vaa_pkg::POS_RIGHT_LIM)
        begin
            // small vector: shift right and keep the low bytes
            shift_amt = pos + 3'd1;
            sx        = ux >> shift_amt;
            sy        = uy >> shift_amt;
            s1_x_next = sx[7:0];
            s1_y_next = sy[7:0];
        end
        else
        begin
            // large vector: shift left, at least once, and keep the high bytes
            shift_amt = (pos >= 3'd6) ? 3'd1 : (vaa_pkg::POS_TOP - pos);
            sx        = ux << shift_amt;
            sy        = uy << shift_amt;
            s1_x_next = sx[15:8];
            s1_y_next = sy[15:8];
        end

        s1_valid_next       = start && !busy;
        s1_req_next.is_load = (req_type == vaa_pkg::REQ_LOAD);
        s1_req_next.idx     = table_index;
        s1_req_next.val     = table_value;
    end

    // ------------------------------------------------------------------
    // Stage 2: fold into the first octant and pick dividend and divisor
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [7:0] mx;
        logic [7:0] my;

        s2_fold_next.neg_y = s1_y_reg[7];
        s2_fold_next.neg_x = s1_x_reg[7];
        my = s1_y_reg[7] ? vaa_pkg::neg8(s1_y_reg) : s1_y_reg;
        mx = s1_x_reg[7] ? vaa_pkg::neg8(s1_x_reg) : s1_x_reg;

        // equal magnitudes take the swapped path
        s2_fold_next.swap = !(my < mx);
        s2_num_next = s2_fold_next.swap ? mx : my;
        s2_den_next = s2_fold_next.swap ? my : mx;
    end

    // ------------------------------------------------------------------
    // Stage 3: first three quotient bits
    // ------------------------------------------------------------------
    always_comb
    begin
        vaa_pkg::div_step_t step;
        logic [7:0]         rem;
        logic [2:0]         q;

        rem = s2_num_reg;
        q   = 3'd0;
        for (int i = 0; i < 3; i++)
        begin
            step = vaa_pkg::div_step(rem, s2_den_reg);
            rem  = step.rem;
            q    = {q[1:0], step.q_bit};
        end
        s3_rem_next = rem;
        s3_q_next   = q;
    end

    // ------------------------------------------------------------------
    // Stage 4: last two quotient bits
    // ------------------------------------------------------------------
    always_comb
    begin
        vaa_pkg::div_step_t step_a;
        vaa_pkg::div_step_t step_b;

        step_a    = vaa_pkg::div_step(s3_rem_reg, s3_den_reg);
        step_b    = vaa_pkg::div_step(step_a.rem, s3_den_reg);
        s4_q_next = {s3_q_reg, step_a.q_bit, step_b.q_bit};
    end

    // ------------------------------------------------------------------
    // Output stage: undo the octant fold on the table angle
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [7:0] a;

        a = s5_data_reg;
        if (s5_fold_reg.swap)
        begin
            a = vaa_pkg::neg8(a - vaa_pkg::ANGLE_QUARTER);
        end
        if (s5_fold_reg.neg_x)
        begin
            a = vaa_pkg::neg8(a ^ vaa_pkg::ANGLE_HALF);
        end
        if (s5_fold_reg.neg_y)
        begin
            a = vaa_pkg::neg8(a);
        end
        angle_next = a;
    end

    // ------------------------------------------------------------------
    // Valid bits: advance every cycle, clear on reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg && !s4_req_reg.is_load;
            done_reg     <= s5_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload: advance with the valid bits, no reset needed
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_req_reg  <= s1_req_next;
        s1_x_reg    <= s1_x_next;
        s1_y_reg    <= s1_y_next;

        s2_req_reg  <= s1_req_reg;
        s2_fold_reg <= s2_fold_next;
        s2_num_reg  <= s2_num_next;
        s2_den_reg  <= s2_den_next;

        s3_req_reg  <= s2_req_reg;
        s3_fold_reg <= s2_fold_reg;
        s3_rem_reg  <= s3_rem_next;
        s3_den_reg  <= s2_den_reg;
        s3_q_reg    <= s3_q_next;

        s4_req_reg  <= s3_req_reg;
        s4_fold_reg <= s3_fold_reg;
        s4_q_reg    <= s4_q_next;

        s5_fold_reg <= s4_fold_reg;

        angle_reg   <= angle_next;
    end

    // ------------------------------------------------------------------
    // Angle table: load beats write, compute beats read, in pipeline order
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && s4_req_reg.is_load)
        begin
            angle_mem[IDX_W'(s4_req_reg.idx)] <= s4_req_reg.val;
        end
        s5_data_reg <= angle_mem[IDX_W'(s4_q_reg)];
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule
